// ===== sv/tcf_pkg.sv =====
// Shared request kinds, result status codes and stamp width for the two-class FIFO.
package tcf_pkg;

    localparam int STAMP_W = 32;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;

    localparam logic [KIND_W-1:0] KIND_ADD0     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD1     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TAKE0    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TAKE1    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TAKE_ANY = 3'd4;

    localparam logic [STAT_W-1:0] STAT_STORED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_GIVEN  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    typedef logic [STAMP_W-1:0] stamp_t;

endpackage

// ===== sv/two_class_fifo_oldest_first_core.sv =====
// Two-class FIFO core: per-class queue memories, arrival stamps, oldest-first take.
// An accepted request moves the core to its execute state; the result strobe is registered from there.
// The core takes no new request while busy; busy holds for the cycle in which the
// registered memory read of both queue heads returns and the request is executed.
// Results cannot be stalled: done marks each result for exactly one cycle.
// Reset (rst_n low, asynchronous): heads, counts and the stamp clear to zero, the core
// goes idle at once; queue memories are not cleared and their contents are used only where written.
module two_class_fifo_oldest_first_core
    import tcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [KIND_W-1:0]    kind,
    input  logic [TAG_WIDTH-1:0] item_tag,
    output logic                 done,
    output logic [STAT_W-1:0]    status,
    output logic [TAG_WIDTH-1:0] out_tag,
    output logic                 out_class,
    output logic [STAMP_W-1:0]   out_stamp
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = TAG_WIDTH + STAMP_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Queue memories: one entry is {tag, stamp}.
    logic [ENT_W-1:0] mem0 [QUEUE_DEPTH];
    logic [ENT_W-1:0] mem1 [QUEUE_DEPTH];

    logic                 state_reg, state_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic [IDX_W-1:0]     head0_reg, head0_next, head1_reg, head1_next;
    logic [CNT_W-1:0]     cnt0_reg, cnt0_next, cnt1_reg, cnt1_next;
    stamp_t               stamp_reg, stamp_next;
    logic [ENT_W-1:0]     rd0_reg, rd1_reg;

    logic                 done_reg, done_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [TAG_WIDTH-1:0] otag_reg, otag_next;
    logic                 ocls_reg, ocls_next;
    stamp_t               ostamp_reg, ostamp_next;

    logic             wr0_en, wr1_en;
    logic [IDX_W-1:0] tail0, tail1;
    logic [ENT_W-1:0] wr_data;
    logic             empty0, empty1, full0, full1;
    logic             older0, pick0;
    stamp_t           stamp_diff;

    // Tail slot: head plus occupancy, folded back once past the end.
    function automatic logic [IDX_W-1:0] tail_slot(input logic [IDX_W-1:0] head,
                                                   input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] sum;
        begin
            sum = CNT_W'(head) + cnt;
            if (sum >= DEPTH_C)
            begin
                sum = sum - DEPTH_C;
            end
            tail_slot = sum[IDX_W-1:0];
        end
    endfunction

    // Advance a read index by one with wrap.
    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] head);
        logic [CNT_W-1:0] sum;
        begin
            sum = CNT_W'(head) + CNT_W'(1);
            if (sum >= DEPTH_C)
            begin
                sum = '0;
            end
            next_slot = sum[IDX_W-1:0];
        end
    endfunction

    assign busy      = state_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign out_tag   = otag_reg;
    assign out_class = ocls_reg;
    assign out_stamp = ostamp_reg;

    assign empty0 = (cnt0_reg == '0);
    assign empty1 = (cnt1_reg == '0);
    assign full0  = (cnt0_reg >= DEPTH_C);
    assign full1  = (cnt1_reg >= DEPTH_C);
    assign tail0  = tail_slot(head0_reg, cnt0_reg);
    assign tail1  = tail_slot(head1_reg, cnt1_reg);
    assign wr_data = {tag_reg, stamp_reg};

    // Wrap-aware age compare of the two head stamps: class0 is older when the
    // difference has its top bit set; equal stamps favor class1.
    assign stamp_diff = rd0_reg[STAMP_W-1:0] - rd1_reg[STAMP_W-1:0];
    assign older0     = stamp_diff[STAMP_W-1];
    // Any-class take: oldest of two heads, else the only non-empty one.
    assign pick0      = (!empty0 && !empty1) ? older0 : !empty0;

    always_comb
    begin
        state_next  = state_reg;
        head0_next  = head0_reg;
        head1_next  = head1_reg;
        cnt0_next   = cnt0_reg;
        cnt1_next   = cnt1_reg;
        stamp_next  = stamp_reg;
        done_next   = 1'b0;
        status_next = STAT_NONE;
        otag_next   = '0;
        ocls_next   = 1'b0;
        ostamp_next = '0;
        wr0_en      = 1'b0;
        wr1_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                unique case (kind_reg)
                    KIND_ADD0:
                    begin
                        if (full0)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr0_en      = 1'b1;
                            cnt0_next   = cnt0_reg + CNT_W'(1);
                            stamp_next  = stamp_reg + STAMP_W'(1);
                            status_next = STAT_STORED;
                        end
                    end
                    KIND_ADD1:
                    begin
                        if (full1)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr1_en      = 1'b1;
                            cnt1_next   = cnt1_reg + CNT_W'(1);
                            stamp_next  = stamp_reg + STAMP_W'(1);
                            status_next = STAT_STORED;
                        end
                    end
                    KIND_TAKE0, KIND_TAKE1, KIND_TAKE_ANY:
                    begin
                        // Class 0 when asked for, or when the any-class pick lands there.
                        if ((kind_reg == KIND_TAKE0) ||
                            ((kind_reg == KIND_TAKE_ANY) && pick0))
                        begin
                            if (!empty0)
                            begin
                                head0_next  = next_slot(head0_reg);
                                cnt0_next   = cnt0_reg - CNT_W'(1);
                                status_next = STAT_GIVEN;
                                otag_next   = rd0_reg[ENT_W-1:STAMP_W];
                                ostamp_next = rd0_reg[STAMP_W-1:0];
                            end
                        end
                        else
                        begin
                            if (!empty1)
                            begin
                                head1_next  = next_slot(head1_reg);
                                cnt1_next   = cnt1_reg - CNT_W'(1);
                                status_next = STAT_GIVEN;
                                otag_next   = rd1_reg[ENT_W-1:STAMP_W];
                                ocls_next   = 1'b1;
                                ostamp_next = rd1_reg[STAMP_W-1:0];
                            end
                        end
                    end
                    default:
                    begin
                        status_next = STAT_NONE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head0_reg <= '0;
            head1_reg <= '0;
            cnt0_reg  <= '0;
            cnt1_reg  <= '0;
            stamp_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head0_reg <= head0_next;
            head1_reg <= head1_next;
            cnt0_reg  <= cnt0_next;
            cnt1_reg  <= cnt1_next;
            stamp_reg <= stamp_next;
            done_reg  <= done_next;
        end
    end

    // Payload: capture the request and the result fields; no reset needed.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            kind_reg <= kind;
            tag_reg  <= item_tag;
        end
        status_reg <= status_next;
        otag_reg   <= otag_next;
        ocls_reg   <= ocls_next;
        ostamp_reg <= ostamp_next;
    end

    // Queue memories: read both heads every cycle, write the tail on a stored add.
    // Heads and contents settle at the execute edge, before the next request's read.
    always_ff @(posedge clk)
    begin
        rd0_reg <= mem0[head0_reg];
        rd1_reg <= mem1[head1_reg];
        if (wr0_en)
        begin
            mem0[tail0] <= wr_data;
        end
        if (wr1_en)
        begin
            mem1[tail1] <= wr_data;
        end
    end

endmodule

// ===== sv/tcf_checker.sv =====
// Port-level checker for the two-class FIFO core, bound into the core module.
module tcf_checker
    import tcf_pkg::*;
#(
    parameter int TAG_WIDTH = 16
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [STAT_W-1:0]    status,
    input logic [TAG_WIDTH-1:0] out_tag,
    input logic                 out_class,
    input logic [STAMP_W-1:0]   out_stamp
);

    // An accepted request holds the core busy for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // Each busy cycle ends with exactly one result strobe and a free core.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("busy cycle not followed by a result");

    // No result appears without a request in flight.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rst_n && $past(rst_n)) |-> $past(busy))
        else $error("result strobe without a request");

    // Results other than a handed-out item carry zero payload.
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_GIVEN)) |->
            ((out_tag == '0) && (out_class == 1'b0) && (out_stamp == '0)))
        else $error("non-item result carries payload");

endmodule

bind two_class_fifo_oldest_first_core tcf_checker #(.TAG_WIDTH(TAG_WIDTH)) u_tcf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .out_tag   (out_tag),
    .out_class (out_class),
    .out_stamp (out_stamp)
);

// ===== tb/tcf_result_checker.sv =====
// Checker for the two-class FIFO core: predicts each result and compares in order.
module tcf_result_checker
    import tcf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic [KIND_W-1:0]    kind,
    input  logic [TAG_WIDTH-1:0] item_tag,
    input  logic                 done,
    input  logic [STAT_W-1:0]    status,
    input  logic [TAG_WIDTH-1:0] out_tag,
    input  logic                 out_class,
    input  logic [STAMP_W-1:0]   out_stamp,
    output int                   errors,
    output int                   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0]    status;
        logic [TAG_WIDTH-1:0] tag;
        logic                 cls;
        stamp_t               stamp;
    } service_t;

    logic [TAG_WIDTH-1:0] lane_tag   [2][QUEUE_DEPTH];
    stamp_t               lane_stamp [2][QUEUE_DEPTH];
    int                   lane_head  [2];
    int                   lane_count [2];
    stamp_t               stamp_next;
    service_t             due_results [$];

    initial
    begin
        errors      = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic service_t add_to(int c, logic [TAG_WIDTH-1:0] t);
        service_t r;
        int       slot;
        r = '0;
        if (lane_count[c] >= QUEUE_DEPTH)
        begin
            r.status = STAT_FULL;
        end
        else
        begin
            slot = (lane_head[c] + lane_count[c]) % QUEUE_DEPTH;
            lane_tag[c][slot]   = t;
            lane_stamp[c][slot] = stamp_next;
            lane_count[c]++;
            stamp_next = stamp_next + 1'b1;
            r.status = STAT_STORED;
        end
        return r;
    endfunction

    function automatic service_t take_from(int c);
        service_t r;
        r = '0;
        if (lane_count[c] == 0)
        begin
            r.status = STAT_NONE;
        end
        else
        begin
            r.status = STAT_GIVEN;
            r.tag    = lane_tag[c][lane_head[c]];
            r.cls    = (c != 0);
            r.stamp  = lane_stamp[c][lane_head[c]];
            lane_head[c] = (lane_head[c] + 1) % QUEUE_DEPTH;
            lane_count[c]--;
        end
        return r;
    endfunction

    function automatic service_t predict_service(logic [KIND_W-1:0] k,
                                                 logic [TAG_WIDTH-1:0] t);
        service_t r;
        stamp_t   age_gap;
        r = '0;
        case (k)
            KIND_ADD0:  r = add_to(0, t);
            KIND_ADD1:  r = add_to(1, t);
            KIND_TAKE0: r = take_from(0);
            KIND_TAKE1: r = take_from(1);
            KIND_TAKE_ANY:
            begin
                if (lane_count[0] != 0 && lane_count[1] != 0)
                begin
                    // class0 wins only when its head is strictly older (wrap-aware)
                    age_gap = lane_stamp[0][lane_head[0]] - lane_stamp[1][lane_head[1]];
                    r = take_from(age_gap[STAMP_W-1] ? 0 : 1);
                end
                else if (lane_count[0] != 0)
                    r = take_from(0);
                else
                    r = take_from(1);
            end
            default: r.status = STAT_NONE;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        service_t want;
        if (!rst_n)
        begin
            lane_head  = '{0, 0};
            lane_count = '{0, 0};
            stamp_next = '0;
            due_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (due_results.size() == 0)
                    report_mismatch("result with nothing due", status, '0);
                else
                begin
                    want = due_results.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", status, want.status);
                    if (out_tag !== want.tag)
                        report_mismatch("out_tag", out_tag, want.tag);
                    if (out_class !== want.cls)
                        report_mismatch("out_class", out_class, want.cls);
                    if (out_stamp !== want.stamp)
                        report_mismatch("out_stamp", out_stamp, want.stamp);
                end
            end
            if (start && !busy)
                due_results.push_back(predict_service(kind, item_tag));
        end
        outstanding = due_results.size();
    end

endmodule

// ===== tb/two_class_fifo_oldest_first_core_tb.sv =====
// Top-level testbench for the two-class FIFO core: stimulus, watchdog and verdict.
module two_class_fifo_oldest_first_core_tb
    import tcf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    localparam int TAG_WIDTH    = 16;
    localparam int RANDOM_ITEMS = 1150;
    localparam int BURST_LEN    = 32;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 4;

    // kinds with no meaning: the core must answer them as empty takes
    localparam logic [KIND_W-1:0] KIND_VOID_FIRST = KIND_TAKE_ANY + 3'd1;
    localparam logic [KIND_W-1:0] KIND_VOID_LAST  = '1;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 start    = 1'b0;
    logic [KIND_W-1:0]    kind     = KIND_ADD0;
    logic [TAG_WIDTH-1:0] item_tag = '0;
    logic                 busy;
    logic                 done;
    logic [STAT_W-1:0]    status;
    logic [TAG_WIDTH-1:0] out_tag;
    logic                 out_class;
    logic [STAMP_W-1:0]   out_stamp;

    int errors;
    int outstanding;
    int quiet_cycles = 0;
    int idle_pct     = 0;

    // sender idle share per phase; the second phase stands for the receiver
    // stall phase, which does not apply since results cannot be held off
    int phase_idle [4] = '{0, 0, 54, 29};

    always #5 clk = ~clk;

    two_class_fifo_oldest_first_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .item_tag  (item_tag),
        .done      (done),
        .status    (status),
        .out_tag   (out_tag),
        .out_class (out_class),
        .out_stamp (out_stamp)
    );

    tcf_result_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .item_tag    (item_tag),
        .done        (done),
        .status      (status),
        .out_tag     (out_tag),
        .out_class   (out_class),
        .out_stamp   (out_stamp),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Watchdog: count cycles in which neither a request nor a result moves,
    // and abort the run once the core looks hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL two_class_fifo_oldest_first_core");
                $finish;
            end
        end
    end

    // Issue one request: idle for a random number of cycles first (drop start
    // at each idle falling edge), then present the request and hold it until
    // a rising edge sees busy low.
    task automatic send_request(logic [KIND_W-1:0] k, logic [TAG_WIDTH-1:0] t);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start    <= 1'b1;
        kind     <= k;
        item_tag <= t;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Pick a request kind: add_pct steers the mix toward filling or draining
    // the queues; a small share of meaningless kinds is mixed in as noise.
    function automatic logic [KIND_W-1:0] pick_kind(int add_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 4)
            return KIND_VOID_FIRST + KIND_W'($urandom_range(2));
        if (roll < 4 + add_pct)
            return $urandom_range(1) ? KIND_ADD1 : KIND_ADD0;
        case ($urandom_range(2))
            0:       return KIND_TAKE0;
            1:       return KIND_TAKE1;
            default: return KIND_TAKE_ANY;
        endcase
    endfunction

    // Stop issuing and hold until every predicted result has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        wait (outstanding == 0);
    endtask

    initial
    begin
        int fill_mix [3] = '{78, 18, 48};
        int counted;
        int add_pct;
        logic [KIND_W-1:0] k;

        // hold reset low, then release it away from the rising edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: takes on empty queues, including the any-class take
        send_request(KIND_TAKE0, 16'h1111);
        send_request(KIND_TAKE1, 16'h2222);
        send_request(KIND_TAKE_ANY, 16'h3333);
        // meaningless kinds: answered as nothing available, state untouched
        send_request(KIND_VOID_FIRST, 16'hFFFF);
        send_request(KIND_VOID_LAST, 16'h0000);
        // extreme tags, then oldest-first across both classes
        send_request(KIND_ADD0, 16'h0000);
        send_request(KIND_ADD1, 16'hFFFF);
        send_request(KIND_TAKE_ANY, '0);
        send_request(KIND_TAKE_ANY, '0);
        // class0 holds one item; fill class1 to the brim, then overflow it
        send_request(KIND_ADD0, 16'hA5A5);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_request(KIND_ADD1, 16'h5A00 + TAG_WIDTH'(i));
        send_request(KIND_ADD1, 16'hDEAD);
        // class0 head is older, then the class1 head takes its turn
        send_request(KIND_TAKE_ANY, '0);
        send_request(KIND_TAKE_ANY, '0);
        drain_results();

        // Random phases: bursts that lean toward filling, draining or a mix,
        // so both queues go through full, empty and wrapped-index states.
        foreach (phase_idle[p])
        begin
            idle_pct = phase_idle[p];
            counted  = 0;
            add_pct  = fill_mix[0];
            while (counted < RANDOM_ITEMS / 4)
            begin
                if (counted % BURST_LEN == 0)
                    add_pct = fill_mix[$urandom_range(2)];
                k = pick_kind(add_pct);
                send_request(k, TAG_WIDTH'($urandom));
                if (k <= KIND_TAKE_ANY)
                    counted++;
            end
            // pause the sender until the core has answered every request
            drain_results();
        end

        // let any trailing strobe show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("PASS two_class_fifo_oldest_first_core");
        else
            $display("FAIL two_class_fifo_oldest_first_core");
        $finish;
    end

endmodule
